FILE: sv/pse_pkg.sv
`default_nettype none
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [2:0] KIND_OPERAND = 3'd0;
    localparam logic [2:0] KIND_ADD     = 3'd1;
    localparam logic [2:0] KIND_SUB     = 3'd2;
    localparam logic [2:0] KIND_MUL     = 3'd3;
    localparam logic [2:0] KIND_DIV     = 3'd4;
    localparam logic [2:0] KIND_FACT    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV0     = 2'd1;
    localparam logic [1:0] ST_NEGFACT  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOADB = 3'd1;
    localparam logic [2:0] OP_LOADA = 3'd2;
    localparam logic [2:0] OP_ARITH = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic       div_start;
        logic       fact_init;
        logic       a_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic step_done;
        logic b_zero;
        logic a_neg;
    } dp_sts_t;

endpackage
`default_nettype wire

FILE: sv/pse_datapath.sv
`default_nettype none
// stack memory, operand registers, shared divide and factorial unit
module pse_datapath #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int CW = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CW-1:0]    rd_idx,
    input  wire logic             wr_en,
    input  wire logic [CW-1:0]    wr_idx,
    input  wire logic             wr_sel_token,
    input  wire logic [31:0]      token_value,
    input  wire logic [2:0]       kind,
    input  wire pse_pkg::dp_cmd_t cmd,
    output pse_pkg::dp_sts_t      sts,
    output logic [31:0]           rd_data
);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] a_reg, b_reg, res_reg, res_next;
    logic [31:0] rem_reg, rem_next, quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;
    logic [31:0] mag_a, mag_b;

    // memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx[AW-1:0]] <= wr_sel_token ? token_value : res_reg;
        rd_data <= mem[rd_idx[AW-1:0]];
    end

    // operand capture; a missing left operand reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.op == pse_pkg::OP_LOADB)
            b_reg <= rd_data;
        if (cmd.op == pse_pkg::OP_LOADA)
            a_reg <= rd_data;
        else if (cmd.a_clear)
            a_reg <= 32'd0;
    end

    assign mag_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, mag_b};

    // one divide bit or one factorial multiply per step
    always_comb
    begin
        res_next = res_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (cmd.div_start)
        begin
            rem_next = 32'd0;
            quo_next = mag_a;
            cnt_next = 6'd32;
            neg_next = a_reg[31] ^ b_reg[31];
        end
        else if (cmd.fact_init)
        begin
            res_next = 32'd1;
            cnt_next = 6'd2;
        end
        else if (cmd.op == pse_pkg::OP_ARITH)
        begin
            case (kind)
                pse_pkg::KIND_ADD: res_next = a_reg + b_reg;
                pse_pkg::KIND_SUB: res_next = a_reg - b_reg;
                pse_pkg::KIND_MUL: res_next = a_reg * b_reg;
                default:           res_next = res_reg;
            endcase
        end
        else if (cmd.op == pse_pkg::OP_STEP)
        begin
            if (kind == pse_pkg::KIND_DIV)
            begin
                if (trial[32])
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    res_next = neg_reg ? (32'd0 - quo_next) : quo_next;
            end
            else
            begin
                if ({26'd0, cnt_reg} <= a_reg)
                    res_next = res_reg * {26'd0, cnt_reg};
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 6'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // a >= 34 gives zero; stepping stops past min(a, 34)
    always_comb
    begin
        sts.b_zero = (b_reg == 32'd0);
        sts.a_neg  = a_reg[31];
        if (kind == pse_pkg::KIND_DIV)
            sts.step_done = (cnt_reg == 6'd1);
        else
            sts.step_done = (cnt_reg == 6'd34) || ({26'd0, cnt_reg} >= a_reg);
    end
endmodule
`default_nettype wire

FILE: sv/pse_ctrl.sv
`default_nettype none
// token sequencer: stack pointer, halt and error state, handshakes
module pse_ctrl #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
    parameter int CW = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [2:0]       req_type,
    input  wire logic             last_token,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            status,
    output logic                  zero_result,
    output logic [CW-1:0]         rd_idx,
    output logic                  wr_en,
    output logic [CW-1:0]         wr_idx,
    output logic                  wr_sel_token,
    output logic [2:0]            kind,
    output pse_pkg::dp_cmd_t      cmd,
    input  wire pse_pkg::dp_sts_t sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDB   = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_LATA  = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_PUSH  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FINRD = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          halt_reg, halt_next;
    logic [1:0]    err_reg, err_next;
    logic [2:0]    kind_reg, kind_next;
    logic          last_reg, last_next;
    logic          zero_reg, zero_next;
    logic          unary;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = err_reg;
    assign zero_result = zero_reg;
    assign kind      = kind_reg;
    assign unary     = (kind_reg == pse_pkg::KIND_FACT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        halt_next  = halt_reg;
        err_next   = err_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        zero_next  = zero_reg;
        rd_idx     = cnt_reg - CW'(1);
        wr_en      = 1'b0;
        wr_idx     = cnt_reg;
        wr_sel_token = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = req_type;
                    last_next = last_token;
                    state_next = S_FIN;
                    if (!halt_reg)
                    begin
                        if (req_type == pse_pkg::KIND_OPERAND)
                        begin
                            if (cnt_reg == CW'(STACK_DEPTH))
                            begin
                                halt_next = 1'b1;
                                err_next  = pse_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                wr_sel_token = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        else if (cnt_reg == '0)
                            halt_next = 1'b1;
                        else if (req_type <= pse_pkg::KIND_FACT)
                            state_next = S_RDB;
                    end
                    if (state_next == S_FIN && !last_token)
                        state_next = S_IDLE;
                end
            end
            // top entry is read again here; pop it from the count
            S_RDB:
            begin
                cnt_next = cnt_reg - CW'(1);
                state_next = unary ? S_LATA : S_RDA;
            end
            S_RDA:
            begin
                cmd.op = pse_pkg::OP_LOADB;
                // one entry only: the left operand is zero
                if (cnt_reg == '0)
                begin
                    cmd.a_clear = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                    state_next = S_LATA;
                end
            end
            S_LATA:
            begin
                cmd.op = pse_pkg::OP_LOADA;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSH;
                case (kind_reg)
                    pse_pkg::KIND_DIV:
                    begin
                        if (sts.b_zero)
                        begin
                            halt_next = 1'b1;
                            err_next = pse_pkg::ST_DIV0;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next = S_STEP;
                        end
                    end
                    pse_pkg::KIND_FACT:
                    begin
                        if (sts.a_neg)
                        begin
                            halt_next = 1'b1;
                            err_next = pse_pkg::ST_NEGFACT;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.fact_init = 1'b1;
                            state_next = S_STEP;
                        end
                    end
                    default: cmd.op = pse_pkg::OP_ARITH;
                endcase
            end
            S_STEP:
            begin
                cmd.op = pse_pkg::OP_STEP;
                if (sts.step_done)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                wr_en = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                zero_next = 1'b1;
                if (!last_reg)
                    state_next = S_IDLE;
                else if (cnt_reg != '0 && err_reg == pse_pkg::ST_OK)
                begin
                    zero_next = 1'b0;
                    state_next = S_FINRD;
                end
                else
                    state_next = S_OUT;
            end
            S_FINRD: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    cnt_next = '0;
                    halt_next = 1'b0;
                    err_next = pse_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            halt_reg  <= 1'b0;
            err_reg   <= pse_pkg::ST_OK;
            kind_reg  <= pse_pkg::KIND_OPERAND;
            last_reg  <= 1'b0;
            zero_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            halt_reg  <= halt_next;
            err_reg   <= err_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
            zero_reg  <= zero_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != pse_pkg::ST_OK |-> halt_reg)
        else $error("error without halt");
    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> cnt_reg == '0 && !halt_reg)
        else $error("no clear after result");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err_reg != pse_pkg::ST_OK |-> zero_reg)
        else $error("error result not zeroed");
`endif
endmodule
`default_nettype wire

FILE: sv/postfix_stack_evaluator_top.sv
`default_nettype none
// channel  signals                                   direction
// in       in_valid in_ready req_type token_value    request into block
//          last_token
// out      out_valid out_ready result_value status   result out of block
//
// an operand is pushed when taken; add, sub, mul pop their operands and push the result
// divide runs on the one-bit-per-cycle divider
// factorial of n steps through 2 to min(n, 34), one multiply per cycle
// a last token also passes the result out, with the wait on out_ready
// asynchronous active-low reset empties the stack; no clearing pass
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic signed [31:0] token_value,
    input  wire logic        last_token,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] result_value,
    output logic [1:0]       status
);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]    rd_idx, wr_idx;
    logic             wr_en, wr_sel_token, zero_result;
    logic [2:0]       kind;
    logic [31:0]      rd_data;
    pse_pkg::dp_cmd_t cmd;
    pse_pkg::dp_sts_t sts;

    pse_ctrl #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .last_token(last_token), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .zero_result(zero_result),
        .rd_idx(rd_idx), .wr_en(wr_en), .wr_idx(wr_idx),
        .wr_sel_token(wr_sel_token), .kind(kind), .cmd(cmd), .sts(sts)
    );

    pse_datapath #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n), .rd_idx(rd_idx), .wr_en(wr_en),
        .wr_idx(wr_idx), .wr_sel_token(wr_sel_token),
        .token_value(token_value), .kind(kind), .cmd(cmd), .sts(sts),
        .rd_data(rd_data)
    );

    // top of stack was read in the cycle before the result shows
    assign result_value = zero_result ? 32'sd0 : $signed(rd_data);
endmodule
`default_nettype wire
